// ===== rtl/kiut_pkg.sv =====
// ----------------------------------------------------------------------------
// kiut_pkg
// Shared types and codes for the keyed insert/update table.
// ----------------------------------------------------------------------------
package kiut_pkg;

    localparam int KEY_W   = 64;
    localparam int PAY_W   = 64;
    localparam int SEQ_W   = 32;
    localparam int STAMP_W = 32;
    localparam int SLOT_W  = 6;

    localparam logic REQ_STORE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        ST_UPDATED  = 3'd0,
        ST_INSERTED = 3'd1,
        ST_FULL     = 3'd2,
        ST_HIT      = 3'd3,
        ST_MISS     = 3'd4
    } t_status;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_OUT
    } t_state;

    typedef struct packed {
        logic [KEY_W-1:0]   key;
        logic [SEQ_W-1:0]   seq;
        logic [STAMP_W-1:0] stamp;
        logic [PAY_W-1:0]   payload;
    } t_entry;

    typedef struct packed {
        t_status            status;
        logic [SLOT_W-1:0]  slot;
        logic [SEQ_W-1:0]   seq;
        logic [STAMP_W-1:0] stamp;
        logic [PAY_W-1:0]   payload;
    } t_result;

endpackage

// ===== rtl/keyed_insert_update_table.sv =====
// An item goes from acceptance through the scan to the output register; the
// scan compares slots up to the hit position, or every used slot on a miss.
// A new item is taken only after the last result has entered the output
// register; the scan reads one slot per cycle through the single read port.
// Reset empties the table by clearing the used count; slot memory is not swept.
// ----------------------------------------------------------------------------
// keyed_insert_update_table
// Key/value slot table with ordered linear search, update and append.
// ----------------------------------------------------------------------------
module keyed_insert_update_table #(
    parameter int ENTRIES      = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_in_valid,
    output logic                             o_in_stall,
    input  logic                             i_req_type,
    input  logic [kiut_pkg::KEY_W-1:0]       i_key_hash,
    input  logic [kiut_pkg::PAY_W-1:0]       i_payload_in,
    input  logic [kiut_pkg::STAMP_W-1:0]     i_now_time,
    output logic                             o_out_valid,
    input  logic                             i_out_stall,
    output logic [2:0]                       o_status,
    output logic [kiut_pkg::SLOT_W-1:0]      o_slot_index,
    output logic [kiut_pkg::SEQ_W-1:0]       o_sequence_out,
    output logic [kiut_pkg::STAMP_W-1:0]     o_stamp_out,
    output logic [kiut_pkg::PAY_W-1:0]       o_payload_out
);

    localparam int AW = $clog2(ENTRIES);

    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    kiut_pkg::t_entry  rd_data;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    kiut_pkg::t_entry  wr_data;
    logic              res_vld;
    kiut_pkg::t_result res;
    logic              out_free;

    logic              r_out_vld;
    kiut_pkg::t_result r_out;

    kiut_store #(
        .ENTRIES      (ENTRIES),
        .PAYLOAD_BITS (PAYLOAD_BITS)
    ) u_store (
        .i_clk     (i_clk),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_data),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    kiut_ctrl #(
        .ENTRIES (ENTRIES)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_req_type   (i_req_type),
        .i_key_hash   (i_key_hash),
        .i_payload_in (i_payload_in),
        .i_now_time   (i_now_time),
        .o_rd_en      (rd_en),
        .o_rd_addr    (rd_addr),
        .i_rd_data    (rd_data),
        .o_wr_en      (wr_en),
        .o_wr_addr    (wr_addr),
        .o_wr_data    (wr_data),
        .o_res_vld    (res_vld),
        .o_res        (res),
        .i_out_free   (out_free)
    );

    assign out_free = !r_out_vld || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (res_vld && out_free) begin
            r_out_vld <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_vld && out_free) begin
            r_out <= res;
        end
    end

    assign o_out_valid    = r_out_vld;
    assign o_status       = r_out.status;
    assign o_slot_index   = r_out.slot;
    assign o_sequence_out = r_out.seq;
    assign o_stamp_out    = r_out.stamp;
    assign o_payload_out  = r_out.payload;

endmodule

// ===== rtl/kiut_store.sv =====
// ----------------------------------------------------------------------------
// kiut_store
// Slot memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kiut_store #(
    parameter int ENTRIES      = 64,
    parameter int PAYLOAD_BITS = 64
) (
    input  logic                       i_clk,
    input  logic                       i_rd_en,
    input  logic [$clog2(ENTRIES)-1:0] i_rd_addr,
    output kiut_pkg::t_entry           o_rd_data,
    input  logic                       i_wr_en,
    input  logic [$clog2(ENTRIES)-1:0] i_wr_addr,
    input  kiut_pkg::t_entry           i_wr_data
);

    logic [kiut_pkg::KEY_W-1:0]   r_key_mem   [ENTRIES];
    logic [kiut_pkg::SEQ_W-1:0]   r_seq_mem   [ENTRIES];
    logic [kiut_pkg::STAMP_W-1:0] r_stamp_mem [ENTRIES];
    logic [PAYLOAD_BITS-1:0]      r_pay_mem   [ENTRIES];

    logic [kiut_pkg::KEY_W-1:0]   r_rd_key;
    logic [kiut_pkg::SEQ_W-1:0]   r_rd_seq;
    logic [kiut_pkg::STAMP_W-1:0] r_rd_stamp;
    logic [PAYLOAD_BITS-1:0]      r_rd_pay;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_key_mem[i_wr_addr]   <= i_wr_data.key;
            r_seq_mem[i_wr_addr]   <= i_wr_data.seq;
            r_stamp_mem[i_wr_addr] <= i_wr_data.stamp;
            r_pay_mem[i_wr_addr]   <= i_wr_data.payload[PAYLOAD_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_key   <= r_key_mem[i_rd_addr];
            r_rd_seq   <= r_seq_mem[i_rd_addr];
            r_rd_stamp <= r_stamp_mem[i_rd_addr];
            r_rd_pay   <= r_pay_mem[i_rd_addr];
        end
    end

    always_comb begin
        o_rd_data.key     = r_rd_key;
        o_rd_data.seq     = r_rd_seq;
        o_rd_data.stamp   = r_rd_stamp;
        o_rd_data.payload = kiut_pkg::PAY_W'(r_rd_pay);
    end

endmodule

// ===== rtl/kiut_ctrl.sv =====
// ----------------------------------------------------------------------------
// kiut_ctrl
// Scan sequencer: streams used slots through one key comparator, then
// updates, appends or reports.
// ----------------------------------------------------------------------------
module kiut_ctrl #(
    parameter int ENTRIES = 64
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_in_valid,
    output logic                               o_in_stall,
    input  logic                               i_req_type,
    input  logic [kiut_pkg::KEY_W-1:0]         i_key_hash,
    input  logic [kiut_pkg::PAY_W-1:0]         i_payload_in,
    input  logic [kiut_pkg::STAMP_W-1:0]       i_now_time,
    output logic                               o_rd_en,
    output logic [$clog2(ENTRIES)-1:0]         o_rd_addr,
    input  kiut_pkg::t_entry                   i_rd_data,
    output logic                               o_wr_en,
    output logic [$clog2(ENTRIES)-1:0]         o_wr_addr,
    output kiut_pkg::t_entry                   o_wr_data,
    output logic                               o_res_vld,
    output kiut_pkg::t_result                  o_res,
    input  logic                               i_out_free
);

    localparam int AW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);

    kiut_pkg::t_state  r_state, n_state;
    logic [CW-1:0]     r_used, n_used;
    logic [CW-1:0]     r_idx, n_idx;
    logic              r_pend;
    logic [AW-1:0]     r_pend_idx;
    kiut_pkg::t_result r_res, n_res;

    logic                          r_req_type;
    logic [kiut_pkg::KEY_W-1:0]    r_key;
    logic [kiut_pkg::PAY_W-1:0]    r_pay;
    logic [kiut_pkg::STAMP_W-1:0]  r_now;

    logic accept;
    logic more;
    logic hit;

    assign accept     = (r_state == kiut_pkg::S_IDLE) && i_in_valid;
    assign o_in_stall = (r_state != kiut_pkg::S_IDLE);
    assign more       = (r_idx < r_used);
    assign hit        = r_pend && (i_rd_data.key == r_key);
    assign o_rd_addr  = r_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= kiut_pkg::S_IDLE;
            r_used  <= '0;
            r_idx   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_used  <= n_used;
            r_idx   <= n_idx;
            r_pend  <= o_rd_en;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_idx <= r_idx[AW-1:0];
        r_res      <= n_res;
        if (accept) begin
            r_req_type <= i_req_type;
            r_key      <= i_key_hash;
            r_pay      <= i_payload_in;
            r_now      <= i_now_time;
        end
    end

    always_comb begin
        n_state   = r_state;
        n_used    = r_used;
        n_idx     = r_idx;
        n_res     = r_res;
        o_rd_en   = 1'b0;
        o_wr_en   = 1'b0;
        o_wr_addr = r_pend_idx;
        o_wr_data = '{key: r_key, seq: i_rd_data.seq + 1'b1, stamp: r_now, payload: r_pay};
        o_res_vld = 1'b0;
        unique case (r_state)
            kiut_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_idx   = '0;
                    n_state = kiut_pkg::S_SCAN;
                end
            end
            kiut_pkg::S_SCAN: begin
                if (hit) begin
                    n_state       = kiut_pkg::S_OUT;
                    n_res.slot    = kiut_pkg::SLOT_W'(r_pend_idx);
                    if (r_req_type == kiut_pkg::REQ_STORE) begin
                        o_wr_en       = 1'b1;
                        n_res.status  = kiut_pkg::ST_UPDATED;
                        n_res.seq     = i_rd_data.seq + 1'b1;
                        n_res.stamp   = r_now;
                        n_res.payload = '0;
                    end else begin
                        n_res.status  = kiut_pkg::ST_HIT;
                        n_res.seq     = i_rd_data.seq;
                        n_res.stamp   = i_rd_data.stamp;
                        n_res.payload = i_rd_data.payload;
                    end
                end else if (!more) begin
                    n_state = kiut_pkg::S_OUT;
                    n_res   = '{status: kiut_pkg::ST_MISS, default: '0};
                    if (r_req_type == kiut_pkg::REQ_STORE) begin
                        if (r_used < CW'(ENTRIES)) begin
                            o_wr_en         = 1'b1;
                            o_wr_addr       = r_used[AW-1:0];
                            o_wr_data.seq   = kiut_pkg::SEQ_W'(1);
                            n_used          = r_used + 1'b1;
                            n_res.status    = kiut_pkg::ST_INSERTED;
                            n_res.slot      = kiut_pkg::SLOT_W'(r_used[AW-1:0]);
                            n_res.seq       = kiut_pkg::SEQ_W'(1);
                            n_res.stamp     = r_now;
                        end else begin
                            n_res.status    = kiut_pkg::ST_FULL;
                        end
                    end
                end else begin
                    o_rd_en = 1'b1;
                    n_idx   = r_idx + 1'b1;
                end
            end
            kiut_pkg::S_OUT: begin
                o_res_vld = 1'b1;
                if (i_out_free) begin
                    n_state = kiut_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = kiut_pkg::S_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

    a_used_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_used <= CW'(ENTRIES))
        else $error("used count beyond table size");

    a_used_only_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kiut_pkg::S_SCAN) |=> (r_used == $past(r_used)))
        else $error("used count changed outside scan");

    a_write_ends_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_wr_en |=> (r_state == kiut_pkg::S_OUT))
        else $error("write did not finish the scan");

    a_res_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res_vld && !i_out_free) |=> ((r_state == kiut_pkg::S_OUT) && $stable(r_res)))
        else $error("pending result lost");

endmodule
